/* rtl/dkvbc_pkg.sv */
// Package for the digit-key Vigenere byte cipher.
// Holds field widths, character constants and configuration register indexes.
// No dependencies.
package dkvbc_pkg;

  localparam int MAX_KEY_DIGITS = 16;
  localparam int DIGIT_W        = 4;
  localparam int KEY_W          = MAX_KEY_DIGITS * DIGIT_W;
  localparam int POS_W          = $clog2(MAX_KEY_DIGITS);
  localparam int LEN_W          = 5;
  localparam int BYTE_W         = 8;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = KEY_W;
  localparam int SUM_W          = 6;

  localparam logic [BYTE_W-1:0]  CHAR_A     = 8'h61;
  localparam logic [BYTE_W-1:0]  CHAR_Z     = 8'h7a;
  localparam logic [BYTE_W-1:0]  CHAR_0     = 8'h30;
  localparam logic [BYTE_W-1:0]  CHAR_9     = 8'h39;
  localparam logic [SUM_W-1:0]   ALPHA_MOD  = 6'd26;
  localparam logic [SUM_W-1:0]   DEC_MOD    = 6'd10;
  localparam logic [DIGIT_W-1:0] DIGIT_MAX  = 4'd9;
  localparam logic [LEN_W-1:0]   LEN_MIN    = 5'd1;
  localparam logic [LEN_W-1:0]   LEN_MAX    = LEN_W'(MAX_KEY_DIGITS);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KEY_DIGITS  = 2'd0,
    REG_KEY_LENGTH  = 2'd1,
    REG_DECODE_MODE = 2'd2
  } cfg_reg_t;

endpackage

/* rtl/digit_key_vigenere_byte_cipher_top.sv */
// Digit-key Vigenere byte cipher, top level.
// The result of each accepted input byte is registered in the output register.
// Throughput: one byte per cycle while the output is taken; the key position counter updates in the same cycle.
// Input ready drops only while the output register holds a result not yet taken.
// Synchronous reset clears the key to zero, key length to 1, encode mode, position 0.
// Depends on dkvbc_pkg.
module digit_key_vigenere_byte_cipher_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [dkvbc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [dkvbc_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [dkvbc_pkg::BYTE_W-1:0]        in_byte,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [dkvbc_pkg::BYTE_W-1:0]        out_byte
);

  logic [dkvbc_pkg::KEY_W-1:0]   key_digits;
  logic [dkvbc_pkg::LEN_W-1:0]   key_length;
  logic                          decode_mode;
  logic [dkvbc_pkg::POS_W-1:0]   key_position;
  logic [dkvbc_pkg::POS_W-1:0]   key_position_next;
  logic [dkvbc_pkg::BYTE_W-1:0]  out_byte_next;

  logic                          in_fire;
  logic [dkvbc_pkg::DIGIT_W-1:0] raw_digit;
  logic [dkvbc_pkg::DIGIT_W-1:0] shift;
  logic [dkvbc_pkg::LEN_W-1:0]   eff_length;
  logic [dkvbc_pkg::LEN_W-1:0]   pos_inc;
  logic                          is_alpha;
  logic                          is_dec;
  logic [dkvbc_pkg::SUM_W-1:0]   modulus;
  logic [dkvbc_pkg::SUM_W-1:0]   offset;
  logic [dkvbc_pkg::SUM_W-1:0]   sum;
  logic [dkvbc_pkg::SUM_W-1:0]   wrapped;
  logic [dkvbc_pkg::BYTE_W-1:0]  base;

  assign in_ready = !out_valid || out_ready;
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    raw_digit = key_digits[key_position*dkvbc_pkg::DIGIT_W +: dkvbc_pkg::DIGIT_W];
    shift     = (raw_digit > dkvbc_pkg::DIGIT_MAX) ? dkvbc_pkg::DIGIT_MAX : raw_digit;

    is_alpha = (in_byte >= dkvbc_pkg::CHAR_A) && (in_byte <= dkvbc_pkg::CHAR_Z);
    is_dec   = (in_byte >= dkvbc_pkg::CHAR_0) && (in_byte <= dkvbc_pkg::CHAR_9);
    base     = is_alpha ? dkvbc_pkg::CHAR_A : dkvbc_pkg::CHAR_0;
    modulus  = is_alpha ? dkvbc_pkg::ALPHA_MOD : dkvbc_pkg::DEC_MOD;
    offset   = dkvbc_pkg::SUM_W'(in_byte - base);

    if (decode_mode) begin
      sum = offset + modulus - dkvbc_pkg::SUM_W'(shift);
    end else begin
      sum = offset + dkvbc_pkg::SUM_W'(shift);
    end
    wrapped = (sum >= modulus) ? (sum - modulus) : sum;

    if (is_alpha || is_dec) begin
      out_byte_next = base + dkvbc_pkg::BYTE_W'(wrapped);
    end else begin
      out_byte_next = in_byte;
    end
  end

  always_comb begin
    if (key_length == '0) begin
      eff_length = dkvbc_pkg::LEN_MIN;
    end else if (key_length > dkvbc_pkg::LEN_MAX) begin
      eff_length = dkvbc_pkg::LEN_MAX;
    end else begin
      eff_length = key_length;
    end
    pos_inc = dkvbc_pkg::LEN_W'(key_position) + dkvbc_pkg::LEN_W'(1);
    key_position_next = (pos_inc >= eff_length) ? '0 : pos_inc[dkvbc_pkg::POS_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_digits  <= '0;
      key_length  <= dkvbc_pkg::LEN_MIN;
      decode_mode <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        dkvbc_pkg::REG_KEY_DIGITS:  key_digits  <= cfg_data;
        dkvbc_pkg::REG_KEY_LENGTH:  key_length  <= cfg_data[dkvbc_pkg::LEN_W-1:0];
        dkvbc_pkg::REG_DECODE_MODE: decode_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_position <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (in_fire) begin
        key_position <= key_position_next;
        out_valid    <= 1'b1;
      end else if (out_ready) begin
        out_valid    <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_byte <= out_byte_next;
    end
  end

endmodule
